### rtl/core/masked_byte_signature_scan_defines.svh
// Assertion helpers shared by the scan RTL.
`ifndef MASKED_BYTE_SIGNATURE_SCAN_DEFINES_SVH
`define MASKED_BYTE_SIGNATURE_SCAN_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define MBSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define MBSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mbss_pkg.sv
package mbss_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS = 3'd4;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned MASK_W    = 16;
    localparam int unsigned PATTERN_W = 128;

    // Per-byte compare outcome handed from the match stage to the report stage
    typedef struct packed {
        logic hit;
        logic last;
    } mbss_flags_t;

endpackage

### rtl/core/mbss_match.sv
`include "masked_byte_signature_scan_defines.svh"

module mbss_match #(
    parameter int PATTERN_MAX = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_valid,
    output logic                           byte_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic [mbss_pkg::PATTERN_W-1:0] pattern,
    input  logic [mbss_pkg::MASK_W-1:0]    care_mask,
    input  logic [mbss_pkg::LEN_W-1:0]     pattern_length,
    output logic                           stage_valid,
    output mbss_pkg::mbss_flags_t          stage_flags,
    output logic [COUNT_BITS-1:0]          stage_offset,
    input  logic                           stage_take
);
    import mbss_pkg::*;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [7:0]            win_reg [PATTERN_MAX];
    logic [7:0]            shifted [PATTERN_MAX];
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [LEN_W-1:0]      eff_len;
    logic                  hit;
    logic                  take;

    logic                  a_valid_reg;
    mbss_flags_t           a_flags_reg;
    logic [COUNT_BITS-1:0] a_offset_reg;

    assign byte_ready = !a_valid_reg || stage_take;
    assign take       = byte_valid && byte_ready;

    // Zero reads as one, anything above the window depth is clamped
    always_comb
    begin
        if (pattern_length == '0)
            eff_len = LEN_W'(1);
        else if (pattern_length > LEN_W'(PATTERN_MAX))
            eff_len = LEN_W'(PATTERN_MAX);
        else
            eff_len = pattern_length;
    end

    // Window as it stands once this byte is shifted in; entry 0 is newest
    always_comb
    begin
        shifted[0] = data_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
            shifted[i] = win_reg[i-1];
    end

    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // Pattern byte k sits at window entry len-1-k
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        idx = '0;
        hit = (count_next >= COUNT_BITS'(eff_len));
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            idx = eff_len - LEN_W'(k) - LEN_W'(1);
            if ((LEN_W'(k) < eff_len) && care_mask[k])
            begin
                if (shifted[idx[IDX_W-1:0]] != pattern[8*k +: 8])
                    hit = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < PATTERN_MAX; i++)
                win_reg[i] <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                count_reg <= '0;
                for (int i = 0; i < PATTERN_MAX; i++)
                    win_reg[i] <= '0;
            end
            else
            begin
                count_reg <= count_next;
                for (int i = 0; i < PATTERN_MAX; i++)
                    win_reg[i] <= shifted[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (take)
            a_valid_reg <= 1'b1;
        else if (stage_take)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_flags_reg.hit  <= hit;
            a_flags_reg.last <= last_byte;
            a_offset_reg     <= count_next - COUNT_BITS'(eff_len);
        end
    end

    assign stage_valid  = a_valid_reg;
    assign stage_flags  = a_flags_reg;
    assign stage_offset = a_offset_reg;

    `MBSS_ASSERT_NXT(a_rearm_clears_count, take && last_byte, count_reg == '0,
        "byte count not cleared after region end")
endmodule

### rtl/core/mbss_report.sv
`include "masked_byte_signature_scan_defines.svh"

module mbss_report #(
    parameter int COUNT_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        stage_valid,
    input  mbss_pkg::mbss_flags_t       stage_flags,
    input  logic [COUNT_BITS-1:0]       stage_offset,
    output logic                        stage_take,
    input  logic [mbss_pkg::DATA_W-1:0] base_address,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic                        found,
    output logic [mbss_pkg::DATA_W-1:0] match_address
);
    import mbss_pkg::*;

    logic              done_reg;
    logic              o_valid_reg;
    logic              o_found_reg;
    logic [DATA_W-1:0] o_addr_reg;
    logic              out_free;
    logic              emit_found;
    logic              emit_none;

    assign out_free   = !o_valid_reg || result_ready;
    assign stage_take = stage_valid && out_free;

    // First hit of the region reports; a region with no hit reports at its end
    assign emit_found = stage_flags.hit && !done_reg;
    assign emit_none  = stage_flags.last && !done_reg && !stage_flags.hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else if (stage_take)
        begin
            if (stage_flags.last)
                done_reg <= 1'b0;
            else if (stage_flags.hit)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (stage_take)
            o_valid_reg <= emit_found || emit_none;
        else if (result_ready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_take && (emit_found || emit_none))
        begin
            o_found_reg <= emit_found;
            o_addr_reg  <= emit_found ? base_address + DATA_W'(stage_offset) : '0;
        end
    end

    assign result_valid  = o_valid_reg;
    assign found         = o_found_reg;
    assign match_address = o_addr_reg;

    `MBSS_ASSERT_IMP(a_none_has_zero_addr, o_valid_reg && !o_found_reg, o_addr_reg == '0,
        "not-found result carries a nonzero address")
    `MBSS_ASSERT_IMP(a_single_found, stage_take && done_reg, !emit_found,
        "second match reported in one region")
    `MBSS_ASSERT_NXT(a_region_end_rearms, stage_take && stage_flags.last, !done_reg,
        "match flag survives region end")
    `MBSS_ASSERT_IMP(a_one_result_kind, stage_take, !(emit_found && emit_none),
        "found and not-found raised together")
endmodule

### rtl/core/masked_byte_signature_scan.sv
// Channel   Signals                                       Direction
// bytes     byte_valid/byte_ready, data_byte, last_byte   in
// results   result_valid/result_ready, found,
//           match_address                                 out
// config    cfg_valid/cfg_ready, cfg_index, cfg_data      in
//
// One byte per cycle unless a result stalls; both stages are registered.
// The match stage compares the whole window combinationally; the report stage adds
// the base address and holds the result register.
// rst_n clears the window, byte count, match flag, stage valids and config registers
// (pattern_length resets to 1).
// A stalled result blocks the report stage, which in turn holds one byte in the
// match stage; cfg_ready is always high.
module masked_byte_signature_scan #(
    parameter int PATTERN_MAX = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             byte_valid,
    output logic                             byte_ready,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             found,
    output logic [mbss_pkg::DATA_W-1:0]      match_address,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbss_pkg::DATA_W-1:0]      cfg_data
);
    import mbss_pkg::*;

    logic [DATA_W-1:0] pattern_low_reg;
    logic [DATA_W-1:0] pattern_high_reg;
    logic [MASK_W-1:0] care_mask_reg;
    logic [LEN_W-1:0]  pattern_len_reg;
    logic [DATA_W-1:0] base_address_reg;

    logic                  stage_valid;
    mbss_flags_t           stage_flags;
    logic [COUNT_BITS-1:0] stage_offset;
    logic                  stage_take;

    // Config writes are always accepted; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= '0;
            pattern_len_reg  <= LEN_W'(1);
            base_address_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                CFG_CARE_MASK:    care_mask_reg    <= cfg_data[MASK_W-1:0];
                CFG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_BASE_ADDRESS: base_address_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Stage 1: shift the byte into the window, count it, masked compare.
    mbss_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_BITS  (COUNT_BITS)
    ) u_match (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .pattern        ({pattern_high_reg, pattern_low_reg}),
        .care_mask      (care_mask_reg),
        .pattern_length (pattern_len_reg),
        .stage_valid    (stage_valid),
        .stage_flags    (stage_flags),
        .stage_offset   (stage_offset),
        .stage_take     (stage_take)
    );

    // Stage 2: first-hit filter per region, address add, result register.
    mbss_report #(
        .COUNT_BITS (COUNT_BITS)
    ) u_report (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage_valid   (stage_valid),
        .stage_flags   (stage_flags),
        .stage_offset  (stage_offset),
        .stage_take    (stage_take),
        .base_address  (base_address_reg),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .found         (found),
        .match_address (match_address)
    );
endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the wildcard byte pattern search.
// Bytes go in on one valid/ready channel; found / match_address come back on another.
// A scoreboard model runs on every accepted byte transfer.
// Each result transfer is checked against the oldest queued expectation.
module tb_top;
    import mbss_pkg::*;

    localparam int unsigned WIN_BYTES      = 16;      // widest pattern the block takes
    localparam int unsigned IDLE_MAX       = 11;      // longest random gap / stall per transfer
    localparam int unsigned LATENCY_PAD    = 6;       // extra wait so the pipe can empty
    localparam int unsigned RX_HOLD_CYCLES = 300;     // long result back-pressure stretch
    localparam int unsigned CHUNK_BYTES    = 128;     // split point a chunked reader would use
    localparam int unsigned PHASE_BYTES    = 40;      // bytes per random phase
    localparam int unsigned PHASE_COUNT    = 12;
    localparam longint unsigned CYCLE_LIMIT = 400000;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG_LOW  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG_HIGH = 3'd7;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        int unsigned gap;       // idle cycles before this byte is offered
    } scan_byte_t;

    typedef struct {
        logic              found;
        logic [DATA_W-1:0] addr;
    } scan_result_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   byte_valid   = 1'b0;
    logic                   byte_ready;
    logic [7:0]             data_byte    = '0;
    logic                   last_byte    = 1'b0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic                   found;
    logic [DATA_W-1:0]      match_address;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [DATA_W-1:0]      cfg_data     = '0;

    masked_byte_signature_scan dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found        (found),
        .match_address(match_address),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Scoreboard model: shadow registers and scan state
    // ------------------------------------------------------------------
    logic [PATTERN_W-1:0] sig_pattern = '0;     // byte k at [8k +: 8]
    logic [MASK_W-1:0]    sig_care    = '0;
    logic [LEN_W-1:0]     sig_len     = 5'd1;
    logic [DATA_W-1:0]    sig_base    = '0;

    logic [7:0]  scan_window [WIN_BYTES] = '{default: 8'h00};  // [0] is newest
    logic [31:0] scan_count = '0;
    bit          scan_hit   = 1'b0;     // match already reported in this region

    scan_result_t expected_results [$];
    scan_byte_t   pending_bytes [$];

    // length 0 acts as 1, anything above the window acts as the full window
    function automatic int unsigned sig_span();
        if (sig_len == 0)
            return 1;
        if (sig_len > WIN_BYTES)
            return WIN_BYTES;
        return sig_len;
    endfunction

    // append one expected result at the tail of the scoreboard queue
    function automatic void expect_result(input logic f, input logic [DATA_W-1:0] a);
        scan_result_t r;
        r.found = f;
        r.addr  = a;
        expected_results = {expected_results, r};
    endfunction

    function automatic void scan_step(input logic [7:0] d, input logic last);
        int unsigned span;
        int unsigned i;
        bit          hit;
        span = sig_span();
        // after a hit the bytes are dropped, only the region end counts
        if (!scan_hit)
        begin
            for (i = WIN_BYTES - 1; i > 0; i--)
                scan_window[i] = scan_window[i-1];
            scan_window[0] = d;
            if (scan_count != '1)
                scan_count++;       // saturating count
            if (scan_count >= span)
            begin
                hit = 1'b1;
                // pattern byte k sits span-1-k places back from the newest byte
                for (i = 0; i < span; i++)
                    if (sig_care[i] && scan_window[span-1-i] != sig_pattern[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    expect_result(1'b1, sig_base + 64'(scan_count) - 64'(span));
                    scan_hit = 1'b1;
                end
            end
        end
        if (last)
        begin
            if (!scan_hit)
                expect_result(1'b0, '0);
            scan_window = '{default: 8'h00};
            scan_count  = '0;
            scan_hit    = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: pops the pending queue, honors each byte's gap,
    // and feeds the model on every accepted transfer.
    // ------------------------------------------------------------------
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned gap_count    = 0;
    bit          tx_idle_on   = 1'b1;
    scan_byte_t  offered;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            data_byte  <= '0;
            last_byte  <= 1'b0;
            gap_count  = 0;
        end
        else
        begin
            if (byte_valid && byte_ready)
            begin
                scan_step(data_byte, last_byte);
                bytes_taken++;
            end
            // valid stays put until the transfer happens
            if (!byte_valid || byte_ready)
            begin
                if (pending_bytes.size() != 0 && gap_count >= pending_bytes[0].gap)
                begin
                    offered = pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                    data_byte  <= offered.data;
                    last_byte  <= offered.last;
                    gap_count  = 0;
                end
                else
                begin
                    byte_valid <= 1'b0;
                    if (pending_bytes.size() != 0)
                        gap_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long back-pressure on the result side, counted here on its own.
    // Each bump of hold_requests buys one stretch of RX_HOLD_CYCLES.
    // ------------------------------------------------------------------
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_cnt      = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_served != hold_requests)
        begin
            hold_cnt <= RX_HOLD_CYCLES;
            hold_served++;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compares each result transfer, then draws a stall.
    // ------------------------------------------------------------------
    int unsigned  stall_count = 0;
    bit           rx_idle_on  = 1'b1;
    int unsigned  error_count = 0;
    scan_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_count  = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: found %0d, match_address %h",
                           found, match_address);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        error_count++;
                    end
                    if (match_address !== want.addr)
                    begin
                        $error("match_address: expected %h, got %h", want.addr, match_address);
                        error_count++;
                    end
                end
                stall_count = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if (hold_cnt != 0)
                result_ready <= 1'b0;
            else if (stall_count != 0)
            begin
                stall_count--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // watchdog
    longint unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // narrow: only 00/FF, so patterns and noise overlap a lot
    function automatic logic [7:0] rand_byte(input bit narrow);
        if (narrow)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_byte(input logic [7:0] d, input logic last);
        scan_byte_t item;
        item.data = d;
        item.last = last;
        item.gap  = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        pending_bytes = {pending_bytes, item};
        bytes_queued++;
    endtask

    // wait for all bytes taken and all results back, then let the pipe empty
    task automatic settle();
        while (bytes_taken != bytes_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    // register write; shadow copy updates on the transfer
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PATTERN_LOW:  sig_pattern[63:0]   = val;
            CFG_PATTERN_HIGH: sig_pattern[127:64] = val;
            CFG_CARE_MASK:    sig_care            = val[MASK_W-1:0];
            CFG_PATTERN_LEN:  sig_len             = val[LEN_W-1:0];
            CFG_BASE_ADDRESS: sig_base            = val;
            default: ;
        endcase
    endtask

    // One region of n bytes. plant: drop the pattern in somewhere (often at
    // the very end); spoil: then break one cared-for byte; close: mark the end.
    task automatic add_region(input int unsigned n, input bit plant, input bit spoil,
                              input bit close, input bit narrow);
        logic [7:0]        bytes [$];
        logic [MASK_W-1:0] care_in_use;
        int unsigned       span;
        int unsigned       pos;
        int unsigned       k;
        int unsigned       pick;
        span = sig_span();
        care_in_use = sig_care & MASK_W'((32'h1 << span) - 1);
        for (k = 0; k < n; k++)
            bytes = {bytes, rand_byte(narrow)};
        if (plant && n >= span)
        begin
            pos = ($urandom_range(0, 3) == 0) ? n - span : $urandom_range(0, n - span);
            for (k = 0; k < span; k++)
                if (sig_care[k])
                    bytes[pos + k] = sig_pattern[8*k +: 8];
            if (spoil && care_in_use != 0)
            begin
                do pick = $urandom_range(0, span - 1); while (!care_in_use[pick]);
                bytes[pos + pick] = ~sig_pattern[8*pick +: 8];
            end
        end
        for (k = 0; k < n; k++)
            queue_byte(bytes[k], close && k == n - 1);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned          phase;
        int unsigned          phase_bytes;
        int unsigned          n;
        int unsigned          r;
        int unsigned          k;
        bit                   narrow;
        bit                   open_tail;
        logic [PATTERN_W-1:0] pat;
        logic [MASK_W-1:0]    care;
        logic [LEN_W-1:0]     len;
        logic [DATA_W-1:0]    base;
        logic [7:0]           chunk_byte;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset config: length 1, no cared bytes, so the first byte hits.
        // Then a byte after the hit that closes the region (no result),
        // then a one-byte region that hits on its last byte.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h5A, 1'b1);
        settle();

        // 4-byte pattern 00 FF ?? 80, byte 2 wildcard; base near the top so
        // addresses wrap. Junk in the upper bits of mask / length writes.
        cfg_write(CFG_PATTERN_LOW,  64'h0000_0000_8033_FF00);
        cfg_write(CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_CARE_MASK,    64'hFFFF_FFFF_FFFF_000B);
        cfg_write(CFG_PATTERN_LEN,  64'hFFFF_FFFF_FFFF_FFE4);
        cfg_write(CFG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFE);
        cfg_write(CFG_NO_REG_LOW,   '1);
        cfg_write(CFG_NO_REG_HIGH,  '0);

        // hit on the last byte at offset 1
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h77, 1'b0);
        queue_byte(8'h80, 1'b1);
        // region shorter than the pattern
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h77, 1'b1);
        // hit at offset 2 wraps the address to 0; trailing byte ignored
        queue_byte(8'h55, 1'b0);
        queue_byte(8'h66, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hAB, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b1);
        settle();

        // length 0 behaves as length 1
        cfg_write(CFG_PATTERN_LEN, 64'h0);
        cfg_write(CFG_CARE_MASK,   64'h1);
        cfg_write(CFG_PATTERN_LOW, 64'h42);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b0);
        queue_byte(8'h43, 1'b1);
        settle();

        // One region with a 12-byte match straddling the split point at
        // CHUNK_BYTES. Pattern bytes have bit 7 set, noise never does.
        tx_idle_on = 1'b0;
        for (k = 0; k < WIN_BYTES; k++)
            pat[8*k +: 8] = 8'h80 | 8'($urandom_range(0, 127));
        cfg_write(CFG_PATTERN_LOW,  pat[63:0]);
        cfg_write(CFG_PATTERN_HIGH, pat[127:64]);
        cfg_write(CFG_CARE_MASK,    64'h0FFF);
        cfg_write(CFG_PATTERN_LEN,  64'd12);
        cfg_write(CFG_BASE_ADDRESS, {32'($urandom), 32'($urandom)});
        for (k = 0; k < CHUNK_BYTES + 14; k++)
        begin
            if (k >= CHUNK_BYTES - 6 && k < CHUNK_BYTES + 6)
                chunk_byte = pat[8*(k - (CHUNK_BYTES - 6)) +: 8];
            else
                chunk_byte = 8'($urandom_range(0, 127));
            queue_byte(chunk_byte, k == CHUNK_BYTES + 13);
        end
        settle();

        // Back-pressure: every byte matches (length 1, all wildcard), two-byte
        // regions back to back, result side held off so the input stalls.
        rx_idle_on = 1'b0;
        cfg_write(CFG_PATTERN_LEN, 64'd1);
        cfg_write(CFG_CARE_MASK,   64'h0);
        hold_requests++;
        for (k = 0; k < 40; k++)
            queue_byte(rand_byte(1'b0), k[0]);
        settle();

        // Random phases: fresh register set each time, then regions that
        // mostly carry the pattern (some spoiled), the rest plain noise.
        // A phase may end inside a region, so the next writes land mid-region.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            narrow     = ($urandom_range(0, 2) == 0);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            open_tail  = ($urandom_range(0, 3) == 0);
            for (k = 0; k < WIN_BYTES; k++)
                pat[8*k +: 8] = rand_byte(narrow);
            case ($urandom_range(0, 3))
                0:       care = '1;
                1:       care = 16'($urandom);
                2:       care = 16'($urandom) & 16'($urandom);
                default: care = '0;
            endcase
            len  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 8));
            base = $urandom_range(0, 1) ? {32'($urandom), 32'($urandom)}
                                        : {48'hFFFF_FFFF_FFFF, 16'($urandom)};
            // pin the extremes in the first few phases
            case (phase)
                0:
                begin
                    pat  = '1;
                    care = '1;
                    len  = 5'd16;
                    base = '1;
                end
                1:
                begin
                    pat  = '0;
                    care = 16'h0001;
                    len  = 5'd1;
                    base = '0;
                end
                2: len = 5'd0;
                3:
                begin
                    len  = 5'd31;       // clamps to the full window
                    care = '1;
                end
                default: ;
            endcase
            cfg_write(CFG_PATTERN_LOW,  pat[63:0]);
            cfg_write(CFG_PATTERN_HIGH, pat[127:64]);
            cfg_write(CFG_CARE_MASK,    {32'($urandom), 16'($urandom), care});
            cfg_write(CFG_PATTERN_LEN,  {32'($urandom), 27'($urandom), len});
            cfg_write(CFG_BASE_ADDRESS, base);
            if ($urandom_range(0, 2) == 0)
                cfg_write(CFG_INDEX_W'($urandom_range(CFG_NO_REG_LOW, CFG_NO_REG_HIGH)),
                          {32'($urandom), 32'($urandom)});

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                : $urandom_range(1, sig_span() + 12);
                r = $urandom_range(0, 19);
                add_region(n, r < 13, r >= 10 && r < 13,
                           !(open_tail && phase_bytes + n >= PHASE_BYTES), narrow);
                phase_bytes += n;
            end
        end
        settle();

        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
